// File: hw/rtl/tknv_pkg.sv
// Shared types, codes and helpers for the timekeeper NVRAM register port.
`default_nettype none

package tknv_pkg;

   localparam int TKNV_WINDOW_DEPTH = 256;

   // Request kinds carried in the slave-side tuser
   typedef enum logic [1:0] {
      REQ_SET_OFFSET = 2'd0,
      REQ_WRITE      = 2'd1,
      REQ_READ       = 2'd2,
      REQ_NONE       = 2'd3
   } req_kind_type;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OSC_STOP  = 3'd1;
   localparam logic [2:0] ST_FREQ_TEST = 3'd2;
   localparam logic [2:0] ST_READ_CLR  = 3'd3;
   localparam logic [2:0] ST_WRITE_CLR = 3'd4;

   // Clock register slots, relative to the clock base
   localparam logic [2:0] REG_CONTROL = 3'd0;
   localparam logic [2:0] REG_SECONDS = 3'd1;
   localparam logic [2:0] REG_MINUTES = 3'd2;
   localparam logic [2:0] REG_HOURS   = 3'd3;
   localparam logic [2:0] REG_WEEKDAY = 3'd4;
   localparam logic [2:0] REG_MDAY    = 3'd5;
   localparam logic [2:0] REG_MONTH   = 3'd6;
   localparam logic [2:0] REG_YEAR    = 3'd7;

   localparam logic [7:0] SEC_RESET   = 8'h80;
   localparam logic [3:0] MSB_NIBBLE  = 4'hF;

   // Binary to two-digit BCD; tens digit taken from the value modulo 100
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [6:0] r;
      logic [3:0] t;
      logic [6:0] ones;
      r = (v >= 7'd100) ? v - 7'd100 : v;
      t = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (r >= 7'(k * 10)) t = 4'(k);
      end
      ones = r - 7'(t * 10);
      return {t, ones[3:0]};
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/timekeeper_nvram_register_port.sv
// Timekeeper NVRAM register port: offset latch, byte window and clock register reads.
//
// Usage:
//  - Requests arrive on req_*: tuser carries the kind (set offset, write byte,
//    read byte), tdata carries the bus byte and the current binary time.
//  - Every request gives exactly one transfer on rsp_*: the read value (ORed
//    with 0xF00, zero for writes) and a warning status.
//  - The top eight bytes of the window are clock registers; time reads return the
//    supplied time as BCD (stored stop/FT bits merged), or the stored byte under stop/FT.
//  - Latency: a result is valid the cycle after its request transfer.
//    Throughput: one request per cycle while the receiver keeps rsp_tready
//    high. The byte store is a RAM read at the next latched offset, so its
//    output holds the byte at the latched offset; each request takes a single pass.
//  - When the receiver stalls, the result stays in the output register and
//    req_tready drops until that result is taken.
//  - After reset a clearing pass writes the whole window (zeros, seconds =
//    0x80, oscillator stopped); req_tready stays low during the pass. The
//    offset latch resets to zero.
`default_nettype none

module timekeeper_nvram_register_port
   import tknv_pkg::*;
#(
   parameter int WINDOW_DEPTH = TKNV_WINDOW_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: bus_data[7:0], now_year[14:8], now_month[18:15], now_mday[23:19],
   //        now_wday[26:24], now_hour[31:27], now_minute[37:32],
   //        now_second[43:38], zero pad[47:44]
   input  wire logic [47:0] req_tdata,
   // tuser: req_type[1:0]
   input  wire logic [1:0]  req_tuser,
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: read_value[11:0], status[14:12], zero pad[15]
   output logic [15:0]      rsp_tdata
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam logic [IDX_W-1:0] CLK_BASE = IDX_W'(WINDOW_DEPTH - 8);
   localparam logic [IDX_W-1:0] CLK_SEC  = IDX_W'(WINDOW_DEPTH - 7);
   localparam logic [IDX_W-1:0] CLK_MIN  = IDX_W'(WINDOW_DEPTH - 6);
   localparam logic [IDX_W-1:0] CLK_WDAY = IDX_W'(WINDOW_DEPTH - 4);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

   // ---- request fields
   req_kind_type req_kind;
   logic [7:0]   bus_data;
   logic [6:0]   now_year;
   logic [3:0]   now_month;
   logic [4:0]   now_mday;
   logic [2:0]   now_wday;
   logic [4:0]   now_hour;
   logic [5:0]   now_minute;
   logic [5:0]   now_second;

   assign req_kind   = req_kind_type'(req_tuser);
   assign bus_data   = req_tdata[7:0];
   assign now_year   = req_tdata[14:8];
   assign now_month  = req_tdata[18:15];
   assign now_mday   = req_tdata[23:19];
   assign now_wday   = req_tdata[26:24];
   assign now_hour   = req_tdata[31:27];
   assign now_minute = req_tdata[37:32];
   assign now_second = req_tdata[43:38];

   // ---- state
   logic [IDX_W-1:0] idx_ff, idx_in;          // offset latch, already reduced
   logic             clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;
   logic             byp_valid_ff, byp_valid_in;
   logic [7:0]       byp_data_ff, byp_data_in;
   logic [7:0]       ctl_ff, ctl_in;          // shadow of control register
   logic [7:0]       sec_ff, sec_in;          // shadow of seconds register
   logic [7:0]       wdy_ff, wdy_in;          // shadow of weekday register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             do_write;
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic [7:0]       ram_rdata;
   logic [7:0]       stored;
   logic [2:0]       reg_sel;
   logic [7:0]       rd_byte;
   logic [11:0]      value;
   logic [2:0]       status;

   // offset modulo window depth, as a constant table over all byte values
   logic [IDX_W-1:0] mod_tbl [256];
   for (genvar i = 0; i < 256; i++) begin : g_mod
      assign mod_tbl[i] = IDX_W'(i % WINDOW_DEPTH);
   end

   assign req_tready = !clr_busy_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign do_write   = accept && (req_kind == REQ_WRITE);

   // ---- byte store; read port tracks the next latched offset
   always_comb begin
      if (clr_busy_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = (clr_addr_ff == CLK_SEC) ? SEC_RESET : 8'h00;
      end else begin
         ram_we    = do_write;
         ram_waddr = idx_ff;
         ram_wdata = bus_data;
      end
   end

   tknv_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   // RAM is read-first: a byte written at the latched offset comes from the bypass
   assign stored  = byp_valid_ff ? byp_data_ff : ram_rdata;
   assign reg_sel = 3'(idx_ff - CLK_BASE);

   // ---- request decode
   always_comb begin
      rd_byte = 8'h00;
      value   = 12'h000;
      status  = ST_OK;
      case (req_kind)
         REQ_WRITE: begin
            if (idx_ff >= CLK_MIN && !ctl_ff[7]) status = ST_WRITE_CLR;
         end
         REQ_READ: begin
            if (idx_ff < CLK_MIN) begin
               if (idx_ff == CLK_SEC)
                  rd_byte = (stored & 8'h80) | to_bcd({1'b0, now_second});
               else
                  rd_byte = stored;
            end else if (sec_ff[7]) begin
               rd_byte = stored;
               status  = ST_OSC_STOP;
            end else if (wdy_ff[6]) begin
               rd_byte = stored;
               status  = ST_FREQ_TEST;
            end else begin
               if (!ctl_ff[6]) status = ST_READ_CLR;
               case (reg_sel)
                  REG_MINUTES: rd_byte = to_bcd({1'b0, now_minute});
                  REG_HOURS:   rd_byte = to_bcd({2'b00, now_hour});
                  REG_WEEKDAY: rd_byte = {stored[7:4], 4'({1'b0, now_wday} + 4'd1)};
                  REG_MDAY:    rd_byte = to_bcd({2'b00, now_mday});
                  REG_MONTH:   rd_byte = to_bcd({3'b000, now_month});
                  default:     rd_byte = to_bcd(now_year);
               endcase
            end
            value = {MSB_NIBBLE, rd_byte};
         end
         default: ;
      endcase
   end

   // ---- next state
   always_comb begin
      idx_in       = idx_ff;
      clr_busy_in  = clr_busy_ff;
      clr_addr_in  = clr_addr_ff;
      byp_valid_in = byp_valid_ff;
      byp_data_in  = byp_data_ff;
      ctl_in       = ctl_ff;
      sec_in       = sec_ff;
      wdy_in       = wdy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == LAST_IDX) clr_busy_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, status, value};
         if (req_kind == REQ_SET_OFFSET) begin
            idx_in       = mod_tbl[bus_data];
            byp_valid_in = 1'b0;
         end
         if (do_write) begin
            byp_valid_in = 1'b1;
            byp_data_in  = bus_data;
            if (idx_ff == CLK_BASE) ctl_in = bus_data;
            if (idx_ff == CLK_SEC)  sec_in = bus_data;
            if (idx_ff == CLK_WDAY) wdy_in = bus_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         byp_valid_ff <= 1'b0;
         ctl_ff       <= 8'h00;
         sec_ff       <= SEC_RESET;
         wdy_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         byp_valid_ff <= byp_valid_in;
         ctl_ff       <= ctl_in;
         sec_ff       <= sec_in;
         wdy_ff       <= wdy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byp_data_ff <= byp_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- checks
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("request taken during clearing pass");

   a_bypass_after_write: assert property (@(posedge clock) disable iff (reset)
      do_write |=> (byp_valid_ff && byp_data_ff == $past(bus_data)))
      else $error("bypass not loaded after write");

   a_sec_shadow: assert property (@(posedge clock) disable iff (reset)
      (do_write && idx_ff == CLK_SEC) |=> (sec_ff == $past(bus_data)))
      else $error("seconds shadow out of step with store");

   a_result_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("transfer accepted without a result");

endmodule

`default_nettype wire

// File: hw/rtl/tknv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tknv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];   // read-first on address collision
   end

endmodule

`default_nettype wire

// File: sim/tb_timekeeper_nvram_register_port.sv
// Self-checking testbench for the timekeeper NVRAM register port.
`default_nettype none

module tb_timekeeper_nvram_register_port;
   import tknv_pkg::*;

   localparam int CLK_BASE      = TKNV_WINDOW_DEPTH - 8;
   localparam int RANDOM_ITEMS  = 750;
   // Cycles without any transfer before the run is declared hung. Covers the
   // clearing pass after reset plus the longest stalls on both sides.
   localparam int STALL_LIMIT   = 4000;
   localparam int MAX_REPORTED  = 10;

   typedef struct {
      logic [11:0] value;
      logic [2:0]  status;
   } access_result_type;

   // ---------------------------------------------------------------------------
   // Clock, reset and DUT
   // ---------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = REQ_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   always #5 clock = ~clock;

   timekeeper_nvram_register_port u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------------------
   // Shared state
   // ---------------------------------------------------------------------------
   // Current time presented with every request (binary)
   logic [6:0] t_year;
   logic [3:0] t_month;
   logic [4:0] t_mday;
   logic [2:0] t_wday;
   logic [4:0] t_hour;
   logic [5:0] t_minute;
   logic [5:0] t_second;

   // Predictor copy of the block's state
   logic [7:0] nv_bytes [TKNV_WINDOW_DEPTH];
   logic [7:0] offset_q;

   access_result_type pending_results[$];
   int unsigned    error_count = 0;
   int unsigned    items_sent  = 0;
   int unsigned    result_count = 0;
   bit             gaps_on = 1'b1;

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   // Two-digit BCD; tens digit from the value modulo 100
   function automatic logic [7:0] bcd2(input int unsigned v);
      return 8'((((v % 100) / 10) << 4) | (v % 10));
   endfunction

   // Apply one accepted request to the predicted state, return its result
   task automatic predict_access(input req_kind_type kind, input logic [47:0] d,
                                 output access_result_type r);
      logic [7:0]  bus;
      logic [6:0]  year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [2:0]  wday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      int unsigned idx;
      logic [7:0]  held;
      logic [7:0]  v;
      logic [2:0]  st;
      {second, minute, hour, wday, mday, month, year, bus} = d[43:0];
      idx = offset_q % TKNV_WINDOW_DEPTH;
      v   = 8'h00;
      st  = ST_OK;
      case (kind)
         REQ_SET_OFFSET: offset_q = bus;
         REQ_WRITE: begin
            // time-register writes warn while the control write bit is clear
            if (idx >= CLK_BASE + REG_MINUTES && !nv_bytes[CLK_BASE + REG_CONTROL][7])
               st = ST_WRITE_CLR;
            nv_bytes[idx] = bus;
         end
         REQ_READ: begin
            held = nv_bytes[idx];
            if (idx < CLK_BASE + REG_MINUTES) begin
               // plain NVRAM, control and seconds
               if (idx == CLK_BASE + REG_SECONDS) v = (held & 8'h80) | bcd2(second);
               else v = held;
            end else if (nv_bytes[CLK_BASE + REG_SECONDS][7]) begin
               v  = held;
               st = ST_OSC_STOP;
            end else if (nv_bytes[CLK_BASE + REG_WEEKDAY][6]) begin
               v  = held;
               st = ST_FREQ_TEST;
            end else begin
               if (!nv_bytes[CLK_BASE + REG_CONTROL][6]) st = ST_READ_CLR;
               case (3'(idx - CLK_BASE))
                  REG_MINUTES: v = bcd2(minute);
                  REG_HOURS:   v = bcd2(hour);
                  REG_WEEKDAY: v = {held[7:4], 4'(wday + 1)};
                  REG_MDAY:    v = bcd2(mday);
                  REG_MONTH:   v = bcd2(month);
                  default:     v = bcd2(year);
               endcase
            end
         end
         default: ;  // undefined kind: no state change
      endcase
      r.value  = (kind == REQ_READ) ? {4'hF, v} : 12'h000;
      r.status = st;
   endtask

   // ---------------------------------------------------------------------------
   // Scoreboard: prediction on request transfer, compare on result transfer.
   // Both handled in one process so same-edge ordering cannot matter.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      access_result_type want;
      logic [11:0]    got_value;
      logic [2:0]     got_status;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_access(req_kind_type'(req_tuser), req_tdata, want);
            pending_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_value  = rsp_tdata[11:0];
            got_status = rsp_tdata[14:12];
            result_count++;
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTED)
                  $display("ERROR: result %0d with nothing expected: value %03h status %0d",
                           result_count, got_value, got_status);
            end else begin
               want = pending_results.pop_front();
               if (got_value !== want.value || got_status !== want.status) begin
                  error_count++;
                  if (error_count <= MAX_REPORTED)
                     $display("ERROR: result %0d: value exp %03h got %03h, status exp %0d got %0d",
                              result_count, want.value, got_value, want.status, got_status);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Idle pattern: mostly no gap, some short, a few long
   // ---------------------------------------------------------------------------
   function automatic int pick_gap();
      int unsigned p;
      if (!gaps_on) return 0;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver side: stalls of random length, driven on the falling edge
   int stall_left = 0;
   always @(negedge clock) begin : rsp_side
      int g;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         g = pick_gap();
         if (g > 0) begin
            stall_left = g - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles without any transfer
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------
   // One request transfer; optional idle gap before it, fields on the falling edge
   task automatic send_item(input req_kind_type kind, input logic [7:0] bus);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'h0, t_second, t_minute, t_hour, t_wday, t_mday, t_month, t_year, bus};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic select_clock_reg(input logic [2:0] slot);
      send_item(REQ_SET_OFFSET, 8'(CLK_BASE + slot));
   endtask

   task automatic set_time(input int y, input int mo, input int d, input int w,
                           input int h, input int mi, input int s);
      t_year   = 7'(y);
      t_month  = 4'(mo);
      t_mday   = 5'(d);
      t_wday   = 3'(w);
      t_hour   = 5'(h);
      t_minute = 6'(mi);
      t_second = 6'(s);
   endtask

   // Mostly legal calendar values, now and then any bit pattern
   task automatic roll_time();
      if ($urandom_range(0, 9) == 0) begin
         set_time($urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 31),
                  $urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 63),
                  $urandom_range(0, 63));
      end else begin
         set_time($urandom_range(0, 99), $urandom_range(1, 12), $urandom_range(1, 31),
                  $urandom_range(0, 6), $urandom_range(0, 23), $urandom_range(0, 59),
                  $urandom_range(0, 59));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // After reset the oscillator is stopped: seconds read keeps the stop bit,
   // time registers return the stored byte with the stop warning.
   task automatic test_reset_state();
      set_time(0, 1, 1, 0, 0, 0, 0);
      select_clock_reg(REG_SECONDS);
      send_item(REQ_READ, 8'h00);
      select_clock_reg(REG_MINUTES);
      send_item(REQ_READ, 8'h00);
      send_item(REQ_SET_OFFSET, 8'h00);
      send_item(REQ_READ, 8'h00);
   endtask

   // Start the oscillator, then hit the write- and read-bit warnings
   task automatic test_control_bits();
      select_clock_reg(REG_SECONDS);
      send_item(REQ_WRITE, 8'h00);
      select_clock_reg(REG_MINUTES);
      send_item(REQ_WRITE, 8'h12);
      send_item(REQ_READ, 8'h00);
   endtask

   // Time reads with read and write bits set, legal maxima and all-ones fields
   task automatic test_clock_reads();
      select_clock_reg(REG_CONTROL);
      send_item(REQ_WRITE, 8'hC0);
      set_time(99, 12, 31, 6, 23, 59, 59);
      select_clock_reg(REG_HOURS);
      send_item(REQ_READ, 8'h00);
      set_time(127, 15, 31, 7, 31, 63, 63);
      select_clock_reg(REG_YEAR);
      send_item(REQ_READ, 8'h00);
   endtask

   // Frequency test bit freezes time reads, then gets cleared again
   task automatic test_freq_test();
      select_clock_reg(REG_WEEKDAY);
      send_item(REQ_WRITE, 8'h40);
      send_item(REQ_READ, 8'h00);
      send_item(REQ_WRITE, 8'h00);
   endtask

   // NVRAM byte at the low end, all-ones data, and an undefined request kind
   task automatic test_nvram_and_noise();
      send_item(REQ_SET_OFFSET, 8'h00);
      send_item(REQ_WRITE, 8'hFF);
      send_item(REQ_READ, 8'h00);
      send_item(REQ_NONE, 8'hA5);
   endtask

   // Offset-then-access sequences with random content, plus random noise
   task automatic test_random_traffic();
      int unsigned start;
      int unsigned ops;
      logic [7:0]  offs;
      logic [7:0]  wdata;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         // occasionally switch between idling and back-to-back stretches
         if ($urandom_range(0, 29) == 0) gaps_on = ($urandom_range(0, 3) != 0);
         roll_time();
         if ($urandom_range(0, 99) < 80) begin
            offs = ($urandom_range(0, 1) == 1) ? 8'(CLK_BASE + $urandom_range(0, 7))
                                              : 8'($urandom_range(0, 255));
            send_item(REQ_SET_OFFSET, offs);
            ops = $urandom_range(1, 3);
            repeat (ops) begin
               roll_time();
               if ($urandom_range(0, 99) < 55) begin
                  send_item(REQ_READ, 8'($urandom));
               end else begin
                  wdata = 8'($urandom);
                  // keep stop and FT mostly clear so time reads stay reachable
                  if (offs == 8'(CLK_BASE + REG_SECONDS))
                     wdata[7] = ($urandom_range(0, 3) == 0);
                  if (offs == 8'(CLK_BASE + REG_WEEKDAY))
                     wdata[6] = ($urandom_range(0, 3) == 0);
                  send_item(REQ_WRITE, wdata);
               end
            end
         end else begin
            send_item(req_kind_type'($urandom_range(0, 3)), 8'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      offset_q = 8'h00;
      foreach (nv_bytes[i]) nv_bytes[i] = 8'h00;
      nv_bytes[CLK_BASE + REG_SECONDS] = SEC_RESET;
      set_time(0, 1, 1, 0, 0, 0, 0);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_control_bits();
      test_clock_reads();
      test_freq_test();
      test_nvram_and_noise();
      test_random_traffic();

      @(negedge clock);
      req_tvalid <= 1'b0;
      // drain; the watchdog bounds this wait
      while (pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/tknv_pkg.sv
hw/rtl/tknv_ram.sv
hw/rtl/timekeeper_nvram_register_port.sv
sim/tb_timekeeper_nvram_register_port.sv
